@@ hw/rtl/htbrl_pkg.sv @@
// Shared types, constants and codes of the hashed token-bucket rate limiter.
`default_nettype none
package htbrl_pkg;

    // FNV-1a 32-bit hash
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Default parameter values
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int ADDR_TEXT_BYTES_DEF = 64;

    // Reset values of the configuration registers
    localparam logic [7:0]  MAX_TOKENS_RST = 8'd3;
    localparam logic [15:0] REFILL_PERIOD_RST = 16'd2;
    localparam logic [15:0] ENTRY_TTL_RST = 16'd60;

    // Iterative divider: 32-bit dividend, divisor up to 17 bits, 4 bits a cycle
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W = 17;
    localparam int DIV_STEPS = 4;
    localparam int DIV_ITERS = DIVIDEND_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_TOKENS    = 2'd0,
        REG_REFILL_PERIOD = 2'd1,
        REG_ENTRY_TTL     = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        CAUSE_TAKEN     = 3'd0,
        CAUSE_RENEWED   = 3'd1,
        CAUSE_COLLISION = 3'd2,
        CAUSE_EMPTY     = 3'd3,
        CAUSE_TOO_LONG  = 3'd4
    } cause_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_META_RD,
        ST_META_CHK,
        ST_TXT_RD,
        ST_TXT_CHK,
        ST_RENEW,
        ST_WR_TEXT,
        ST_REFILL,
        ST_DIV_WAIT,
        ST_TAKE,
        ST_FINISH
    } state_t;

    // Status of the address front end
    typedef struct packed {
        logic [31:0] hash;
        logic        too_long;
    } front_status_t;

    // One table slot
    typedef struct packed {
        logic        occupied;
        logic [31:0] hash;
        logic [7:0]  tokens;
        logic [31:0] refill_time;
    } meta_t;

endpackage
`default_nettype wire

@@ hw/rtl/htbrl_hasher.sv @@
// Address front end: FNV-1a hash, character count and pending address text.
`default_nettype none
module htbrl_hasher #(
    parameter int ADDR_TEXT_BYTES = htbrl_pkg::ADDR_TEXT_BYTES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  char_accept,
    input  wire logic [7:0]                            char_in,
    input  wire logic                                  clear,
    input  wire logic [$clog2((ADDR_TEXT_BYTES+7)/8)-1:0] rd_word_idx,
    output logic      [63:0]                           rd_word,
    output htbrl_pkg::front_status_t                   status
);
    localparam int TW = (ADDR_TEXT_BYTES + 7) / 8;
    localparam int WW = $clog2(TW);
    localparam int CW = $clog2(ADDR_TEXT_BYTES + 2);

    logic [31:0]     hash_reg;
    logic [31:0]     hash_next;
    logic [31:0]     mix;
    logic [CW-1:0]   count_reg;
    logic [7:0][7:0] pend_reg [TW];

    // Fold one character into the hash
    always_comb begin
        mix = hash_reg ^ {24'd0, char_in};
        hash_next = 32'(mix * htbrl_pkg::FNV_PRIME);
    end

    // Accumulate hash, count and text; drop characters past the buffer
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            hash_reg <= htbrl_pkg::FNV_BASIS;
            count_reg <= '0;
            for (int k = 0; k < TW; k++) begin
                pend_reg[k] <= '0;
            end
        end else if (char_accept) begin
            hash_reg <= hash_next;
            if (count_reg < CW'(ADDR_TEXT_BYTES)) begin
                pend_reg[count_reg[WW+2:3]][count_reg[2:0]] <= char_in;
            end
            if (count_reg <= CW'(ADDR_TEXT_BYTES)) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    assign rd_word = pend_reg[rd_word_idx];
    assign status.hash = hash_reg;
    assign status.too_long = count_reg > CW'(ADDR_TEXT_BYTES);

endmodule
`default_nettype wire

@@ hw/rtl/htbrl_div.sv @@
// Iterative restoring divider, four quotient bits per cycle.
`default_nettype none
module htbrl_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [htbrl_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [htbrl_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                     busy,
    output logic                                     done,
    output logic      [htbrl_pkg::DIVIDEND_W-1:0]    quotient
);
    localparam int NW = htbrl_pkg::DIVIDEND_W;
    localparam int DW = htbrl_pkg::DIVISOR_W;
    localparam int CNTW = htbrl_pkg::DIV_CNT_W;

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   dvd_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dvs_reg;
    logic [NW-1:0]   dvd_next;
    logic [NW-1:0]   quo_next;
    logic [DW-1:0]   rem_next;

    // Shift in four dividend bits, subtract where the divisor fits
    always_comb begin
        logic [DW:0] trial;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial = '0;
        for (int i = 0; i < htbrl_pkg::DIV_STEPS; i++) begin
            trial = {rem_next, dvd_next[NW-1]};
            dvd_next = {dvd_next[NW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                trial = trial - {1'b0, dvs_reg};
                quo_next = {quo_next[NW-2:0], 1'b1};
            end else begin
                quo_next = {quo_next[NW-2:0], 1'b0};
            end
            rem_next = trial[DW-1:0];
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(htbrl_pkg::DIV_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ hw/rtl/hashed_token_bucket_rate_limiter.sv @@
// Top level: sequencer, slot table memories and configuration registers.
//
// Client addresses arrive one character per transaction and are taken one per
// cycle while idle. The character marked last starts a verdict, during which
// no input is taken. The slot is the low bits of the hash, so TABLE_ENTRIES
// must be a power of two. A verdict selects the slot and reads its header,
// compares the stored text one 64-bit word at a time (only when the stored
// hash matches), for a new or expired entry writes a renewed one (header,
// then its text words), runs the divider when whole refill periods must be
// counted, updates the tokens and posts the result. The result is held while
// an earlier one still waits to be taken. Over-long addresses are answered
// without a slot lookup. After reset the block runs a clearing pass over the
// slot table before it takes its first character; configuration writes are
// taken at any time.
`default_nettype none
module hashed_token_bucket_rate_limiter #(
    parameter int TABLE_ENTRIES = htbrl_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_TEXT_BYTES = htbrl_pkg::ADDR_TEXT_BYTES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_addr_char,
    input  wire logic                              s_is_last,
    input  wire logic [31:0]                       s_now_sec,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_allowed,
    output logic      [2:0]                        m_cause,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [htbrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                       cfg_data
);
    localparam int TW = (ADDR_TEXT_BYTES + 7) / 8;
    localparam int WW = $clog2(TW);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TEXT_DEPTH = TABLE_ENTRIES * (2 ** WW);

    htbrl_pkg::state_t        state_reg, state_next;
    htbrl_pkg::front_status_t front;
    htbrl_pkg::meta_t         meta_mem [TABLE_ENTRIES];
    htbrl_pkg::meta_t         meta_q;
    htbrl_pkg::meta_t         meta_wd;
    htbrl_pkg::cause_t        res_cause_reg, m_cause_reg;

    logic [63:0]      text_mem [TEXT_DEPTH];
    logic [63:0]      text_q;
    logic [63:0]      pend_word;

    logic [7:0]       max_tokens_reg;
    logic [15:0]      refill_period_reg;
    logic [15:0]      entry_ttl_reg;

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [WW-1:0]    word_reg;
    logic [31:0]      now_reg;
    logic [31:0]      elapsed_reg;
    logic             elapsed_pos_reg;
    logic             expire_reg;
    logic             mismatch_reg;
    logic [7:0]       tokens_reg;
    logic             refill_upd_reg;
    logic             res_allowed_reg;
    logic             m_valid_reg, m_allowed_reg;

    logic             s_accept;
    logic             out_load;
    logic             hasher_clear;
    logic             meta_we;
    logic [IDX_W-1:0] meta_wa;
    logic             text_we;
    logic             div_start, div_busy, div_done;
    logic [31:0]      div_dividend, div_quo;
    logic [htbrl_pkg::DIVISOR_W-1:0] div_divisor;

    logic [32:0]      diff;
    logic             mm_now;
    logic [32:0]      refill_sum;
    logic [15:0]      period_eff;

    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    htbrl_hasher #(
        .ADDR_TEXT_BYTES(ADDR_TEXT_BYTES)
    ) u_hasher (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_accept(s_accept),
        .char_in    (s_addr_char),
        .clear      (hasher_clear),
        .rd_word_idx(word_reg),
        .rd_word    (pend_word),
        .status     (front)
    );

    htbrl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Slot metadata memory
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_q <= meta_mem[slot_reg];
    end

    // Slot text memory, one 64-bit word per access
    always_ff @(posedge aclk) begin
        if (text_we) begin
            text_mem[{slot_reg, word_reg}] <= pend_word;
        end
        text_q <= text_mem[{slot_reg, word_reg}];
    end

    // Derived values
    always_comb begin
        diff = {1'b0, now_reg} - {1'b0, meta_q.refill_time};
        mm_now = mismatch_reg || (text_q != pend_word);
        refill_sum = 33'(div_quo) + 33'(tokens_reg);
        period_eff = (refill_period_reg == 16'd0) ? 16'd1 : refill_period_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            htbrl_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = htbrl_pkg::ST_IDLE;
                end
            end
            htbrl_pkg::ST_IDLE: begin
                if (s_accept && s_is_last) begin
                    state_next = htbrl_pkg::ST_MOD;
                end
            end
            htbrl_pkg::ST_MOD: begin
                state_next = front.too_long ? htbrl_pkg::ST_FINISH : htbrl_pkg::ST_META_RD;
            end
            htbrl_pkg::ST_META_RD: begin
                state_next = htbrl_pkg::ST_META_CHK;
            end
            htbrl_pkg::ST_META_CHK: begin
                if (!meta_q.occupied || meta_q.hash != front.hash) begin
                    state_next = htbrl_pkg::ST_RENEW;
                end else begin
                    state_next = htbrl_pkg::ST_TXT_RD;
                end
            end
            htbrl_pkg::ST_TXT_RD: begin
                state_next = htbrl_pkg::ST_TXT_CHK;
            end
            htbrl_pkg::ST_TXT_CHK: begin
                priority if (word_reg != WW'(TW - 1)) begin
                    state_next = htbrl_pkg::ST_TXT_RD;
                end else if (mm_now) begin
                    state_next = htbrl_pkg::ST_FINISH;
                end else if (expire_reg) begin
                    state_next = htbrl_pkg::ST_RENEW;
                end else if (elapsed_pos_reg) begin
                    state_next = htbrl_pkg::ST_REFILL;
                end else begin
                    state_next = htbrl_pkg::ST_TAKE;
                end
            end
            htbrl_pkg::ST_RENEW: begin
                state_next = htbrl_pkg::ST_WR_TEXT;
            end
            htbrl_pkg::ST_WR_TEXT: begin
                if (word_reg == WW'(TW - 1)) begin
                    state_next = htbrl_pkg::ST_FINISH;
                end
            end
            htbrl_pkg::ST_REFILL: begin
                state_next = htbrl_pkg::ST_DIV_WAIT;
            end
            htbrl_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = htbrl_pkg::ST_TAKE;
                end
            end
            htbrl_pkg::ST_TAKE: begin
                state_next = htbrl_pkg::ST_FINISH;
            end
            htbrl_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = htbrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = htbrl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs and memory write ports
    always_comb begin
        s_ready = 1'b0;
        out_load = 1'b0;
        hasher_clear = 1'b0;
        meta_we = 1'b0;
        meta_wa = slot_reg;
        meta_wd = '0;
        text_we = 1'b0;
        div_start = 1'b0;
        div_dividend = elapsed_reg;
        div_divisor = {1'b0, period_eff};
        unique case (state_reg)
            htbrl_pkg::ST_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = clr_cnt_reg;
            end
            htbrl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            htbrl_pkg::ST_RENEW: begin
                meta_we = 1'b1;
                meta_wd.occupied = 1'b1;
                meta_wd.hash = front.hash;
                meta_wd.tokens = (max_tokens_reg == 8'd0) ? 8'd0 : max_tokens_reg - 8'd1;
                meta_wd.refill_time = now_reg;
            end
            htbrl_pkg::ST_WR_TEXT: begin
                text_we = 1'b1;
            end
            htbrl_pkg::ST_REFILL: begin
                div_start = 1'b1;
            end
            htbrl_pkg::ST_TAKE: begin
                meta_we = 1'b1;
                meta_wd.occupied = 1'b1;
                meta_wd.hash = meta_q.hash;
                meta_wd.tokens = (tokens_reg != 8'd0) ? tokens_reg - 8'd1 : 8'd0;
                meta_wd.refill_time = refill_upd_reg ? now_reg : meta_q.refill_time;
            end
            htbrl_pkg::ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
                hasher_clear = out_load;
            end
            default: begin
            end
        endcase
    end

    // Control registers: state, clearing pass, configuration, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= htbrl_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            max_tokens_reg <= htbrl_pkg::MAX_TOKENS_RST;
            refill_period_reg <= htbrl_pkg::REFILL_PERIOD_RST;
            entry_ttl_reg <= htbrl_pkg::ENTRY_TTL_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == htbrl_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cfg_valid) begin
                case (cfg_index)
                    htbrl_pkg::REG_MAX_TOKENS:    max_tokens_reg <= cfg_data[7:0];
                    htbrl_pkg::REG_REFILL_PERIOD: refill_period_reg <= cfg_data;
                    htbrl_pkg::REG_ENTRY_TTL:     entry_ttl_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Verdict datapath
    always_ff @(posedge aclk) begin
        if (s_accept && s_is_last) begin
            now_reg <= s_now_sec;
        end
        if (out_load) begin
            m_allowed_reg <= res_allowed_reg;
            m_cause_reg <= res_cause_reg;
        end
        unique case (state_reg)
            htbrl_pkg::ST_MOD: begin
                slot_reg <= front.hash[IDX_W-1:0];
                res_allowed_reg <= 1'b0;
                res_cause_reg <= htbrl_pkg::CAUSE_TOO_LONG;
            end
            htbrl_pkg::ST_META_CHK: begin
                elapsed_reg <= diff[31:0];
                elapsed_pos_reg <= !diff[32] && (diff[31:0] != 32'd0);
                expire_reg <= !diff[32] && (diff[31:0] > {16'd0, entry_ttl_reg});
                tokens_reg <= meta_q.tokens;
                refill_upd_reg <= 1'b0;
                mismatch_reg <= 1'b0;
                word_reg <= '0;
            end
            htbrl_pkg::ST_TXT_CHK: begin
                mismatch_reg <= mm_now;
                if (word_reg != WW'(TW - 1)) begin
                    word_reg <= word_reg + WW'(1);
                end else begin
                    res_allowed_reg <= 1'b0;
                    res_cause_reg <= htbrl_pkg::CAUSE_COLLISION;
                end
            end
            htbrl_pkg::ST_RENEW: begin
                word_reg <= '0;
                res_allowed_reg <= 1'b1;
                res_cause_reg <= htbrl_pkg::CAUSE_RENEWED;
            end
            htbrl_pkg::ST_WR_TEXT: begin
                if (word_reg != WW'(TW - 1)) begin
                    word_reg <= word_reg + WW'(1);
                end
            end
            htbrl_pkg::ST_DIV_WAIT: begin
                if (div_done && div_quo != 32'd0) begin
                    tokens_reg <= (refill_sum > {25'd0, max_tokens_reg})
                        ? max_tokens_reg : refill_sum[7:0];
                    refill_upd_reg <= 1'b1;
                end
            end
            htbrl_pkg::ST_TAKE: begin
                res_allowed_reg <= tokens_reg != 8'd0;
                res_cause_reg <= (tokens_reg != 8'd0)
                    ? htbrl_pkg::CAUSE_TAKEN : htbrl_pkg::CAUSE_EMPTY;
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_allowed = m_allowed_reg;
    assign m_cause = m_cause_reg;

    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    // No characters taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == htbrl_pkg::ST_CLEAR) |-> !s_ready)
        else $error("input taken during table clear");

    // Divider started only when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // Text written only right after a renewed slot header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (text_we && word_reg == '0) |-> $past(state_reg) == htbrl_pkg::ST_RENEW)
        else $error("text write without renewal");

endmodule
`default_nettype wire
